// ===== src/hrhp_pkg.sv =====
// Shared types, constants and name tables of the HTTP request header parser.
package hrhp_pkg;

    // Width of the request byte counter and of the reported length field.
    localparam int LENGTH_BITS  = 16;
    localparam int LEN_OUT_BITS = 16;

    // Longest name in any table, in characters.
    localparam int MAX_NAME = 24;
    localparam int STR_BITS = 8 * MAX_NAME;

    // Result event codes.
    localparam logic [2:0] EV_URL_BYTE   = 3'd0;
    localparam logic [2:0] EV_URL_END    = 3'd1;
    localparam logic [2:0] EV_METHOD     = 3'd2;
    localparam logic [2:0] EV_VERSION    = 3'd3;
    localparam logic [2:0] EV_VALUE_BYTE = 3'd4;
    localparam logic [2:0] EV_VALUE_END  = 3'd5;
    localparam logic [2:0] EV_DONE       = 3'd6;
    localparam logic [2:0] EV_ERROR      = 3'd7;

    // Parse phases.
    localparam logic [2:0] PH_METHOD     = 3'd0;
    localparam logic [2:0] PH_URL        = 3'd1;
    localparam logic [2:0] PH_VERSION    = 3'd2;
    localparam logic [2:0] PH_NAME       = 3'd3;
    localparam logic [2:0] PH_VALUE      = 3'd4;
    localparam logic [2:0] PH_LF         = 3'd5;
    localparam logic [2:0] PH_LINE_START = 3'd6;
    localparam logic [2:0] PH_BLANK_CR   = 3'd7;

    // Name table selection.
    localparam logic [1:0] TSEL_METHOD  = 2'd0;
    localparam logic [1:0] TSEL_VERSION = 2'd1;
    localparam logic [1:0] TSEL_FIELD   = 2'd2;

    // Header field code meaning that the header is not one we report.
    localparam logic [3:0] NO_FIELD = 4'd8;
    localparam logic [4:0] POS_MAX  = 5'd31;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Name tables, already in upper case, right-aligned in a fixed word.
    localparam logic [STR_BITS-1:0] METHOD_STR [7] = '{
        "GET", "POST", "HEAD", "PUT", "DELETE", "TRACE", "CONNECT"
    };
    localparam logic [4:0] METHOD_LEN [7] = '{
        5'd3, 5'd4, 5'd4, 5'd3, 5'd6, 5'd5, 5'd7
    };
    localparam logic [STR_BITS-1:0] VERSION_STR [2] = '{
        "HTTP/1.0", "HTTP/1.1"
    };
    localparam logic [4:0] VERSION_LEN [2] = '{5'd8, 5'd8};
    localparam logic [STR_BITS-1:0] FIELD_STR [8] = '{
        "CONNECTION", "UPGRADE", "ORIGIN", "SEC-WEBSOCKET-KEY",
        "SEC-WEBSOCKET-EXTENSIONS", "SEC-WEBSOCKET-ACCEPT",
        "SEC-WEBSOCKET-PROTOCOL", "SEC-WEBSOCKET-VERSION"
    };
    localparam logic [4:0] FIELD_LEN [8] = '{
        5'd10, 5'd7, 5'd6, 5'd17, 5'd24, 5'd20, 5'd22, 5'd21
    };

    // One result beat, with its valid flag.
    typedef struct packed {
        logic                    valid;
        logic [2:0]              event_res;
        logic [2:0]              code;
        logic [7:0]              data;
        logic [LEN_OUT_BITS-1:0] length;
    } hrhp_res_t;

    // Upper-case fold of an ASCII letter.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Length of table entry k, zero where the table has no such entry.
    function automatic logic [4:0] tab_len(input logic [1:0] tsel, input logic [2:0] k);
        logic [4:0] r;
        r = 5'd0;
        case (tsel)
            TSEL_METHOD:
            begin
                if (k < 3'd7)
                begin
                    r = METHOD_LEN[k];
                end
            end
            TSEL_VERSION:
            begin
                if (k < 3'd2)
                begin
                    r = VERSION_LEN[k[0]];
                end
            end
            default:
            begin
                r = FIELD_LEN[k];
            end
        endcase
        return r;
    endfunction

    // Character at position pos of table entry k, zero past its end.
    function automatic logic [7:0] tab_char(input logic [1:0] tsel, input logic [2:0] k,
                                            input logic [4:0] pos);
        logic [STR_BITS-1:0] s;
        logic [4:0]          n;
        logic [4:0]          back;
        logic [7:0]          r;
        n    = tab_len(tsel, k);
        back = n - pos - 5'd1;
        r    = 8'h00;
        case (tsel)
            TSEL_METHOD:  s = (k < 3'd7) ? METHOD_STR[k] : '0;
            TSEL_VERSION: s = (k < 3'd2) ? VERSION_STR[k[0]] : '0;
            default:      s = FIELD_STR[k];
        endcase
        if (pos < n)
        begin
            r = s[{back, 3'b000} +: 8];
        end
        return r;
    endfunction

endpackage

// ===== src/hrhp_ifs.sv =====
// Valid/ready channel interfaces for request bytes and parser results.
interface hrhp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    logic       start_req;

    modport source (output valid, output byte_req, output start_req, input ready);
    modport sink (input valid, input byte_req, input start_req, output ready);
endinterface

interface hrhp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [2:0]  code;
    logic [7:0]  data;
    logic [15:0] length;

    modport source (output valid, output event_res, output code, output data,
                    output length, input ready);
    modport sink (input valid, input event_res, input code, input data,
                  input length, output ready);
endinterface

// ===== src/http_request_header_parser_core.sv =====
// Top level of the HTTP request header parser: input beat register, parser step, result register.
//
// The parser takes one request byte per beat and can accept a beat in every
// cycle. A byte is held in an input register and stepped through the parser's
// combinational match and phase logic. Its result, if it has one, is loaded
// into an output register when the byte is stepped, and the sink takes it from
// there. Bytes that cause no result simply update the state. Method, version
// and header names are matched against all table entries in parallel, one
// character per byte. A result that waits on the sink stalls the step stage,
// and the input register keeps taking a byte while it is empty.
module http_request_header_parser_core (
    input logic       clk,
    input logic       rst_n,
    hrhp_req_if.sink  req,
    hrhp_res_if.source res
);
    import hrhp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       out_valid_reg;
    hrhp_res_t  out_reg;
    hrhp_res_t  step_res;
    logic       adv;

    // The held byte is stepped when the result register can take its result.
    assign adv       = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || adv;

    // Input beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            byte_reg  <= req.byte_req;
            start_reg <= req.start_req;
        end
    end

    hrhp_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .byte_in  (byte_reg),
        .start    (start_reg),
        .step_res (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && step_res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && step_res.valid)
        begin
            out_reg <= step_res;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.event_res = out_reg.event_res;
    assign res.code      = out_reg.code;
    assign res.data      = out_reg.data;
    assign res.length    = out_reg.length;

endmodule

// ===== src/hrhp_match.sv =====
// Parallel case-insensitive name matcher against the method, version and header tables.
module hrhp_match (
    input  logic [1:0] tsel,
    input  logic [4:0] pos,
    input  logic [7:0] mask,
    input  logic [7:0] byte_in,
    output logic [7:0] mask_next,
    output logic       hit,
    output logic [2:0] hit_idx
);
    import hrhp_pkg::*;

    logic [7:0] folded;

    assign folded = fold(byte_in);

    // Each candidate survives only if its character at this position matches.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            mask_next[k] = mask[k] && (tab_char(tsel, 3'(k), pos) == folded);
        end
    end

    // A token names an entry when that entry is still a candidate and the
    // token is exactly as long as the entry; the lowest such entry wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (mask[k] && tab_len(tsel, 3'(k)) != 5'd0 && tab_len(tsel, 3'(k)) == pos)
            begin
                hit     = 1'b1;
                hit_idx = 3'(k);
            end
        end
    end

endmodule

// ===== src/hrhp_step.sv =====
// Parser state and the combinational step that turns one request byte into at most one result.
module hrhp_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [7:0]        byte_in,
    input  logic              start,
    output hrhp_pkg::hrhp_res_t step_res
);
    import hrhp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    logic [2:0]             phase_reg, phase_next;
    logic                   skip_reg, skip_next;
    logic                   exempt_reg, exempt_next;
    logic [4:0]             pos_reg, pos_next;
    logic [7:0]             mask_reg, mask_next;
    logic [3:0]             field_reg, field_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic                   fin_reg, fin_next;

    // State as seen by this byte: a start beat clears everything first.
    logic [2:0]             eff_phase;
    logic                   eff_skip;
    logic                   eff_exempt;
    logic [4:0]             eff_pos;
    logic [7:0]             eff_mask;
    logic [3:0]             eff_field;
    logic [LENGTH_BITS-1:0] eff_cnt;
    logic                   eff_fin;

    logic [1:0] m_tsel;
    logic [4:0] m_pos;
    logic [7:0] m_mask;
    logic [7:0] m_mask_next;
    logic       m_hit;
    logic [2:0] m_idx;

    logic tok;
    logic tc;
    logic tc_first;
    logic err;

    always_comb
    begin
        eff_phase  = start ? PH_METHOD : phase_reg;
        eff_skip   = start ? 1'b0 : skip_reg;
        eff_exempt = start ? 1'b0 : exempt_reg;
        eff_pos    = start ? 5'd0 : pos_reg;
        eff_mask   = start ? 8'hFF : mask_reg;
        eff_field  = start ? NO_FIELD : field_reg;
        eff_cnt    = start ? '0 : cnt_reg;
        eff_fin    = start ? 1'b0 : fin_reg;
    end

    // Matcher inputs follow the token that this byte actually lands in. At
    // the start of a header line a fresh name begins. After a CR that did
    // not end the header block, the CR is already the name's first
    // character, which matches no name, so the mask is empty at position one.
    always_comb
    begin
        case (eff_phase)
            PH_METHOD:  m_tsel = TSEL_METHOD;
            PH_VERSION: m_tsel = TSEL_VERSION;
            default:    m_tsel = TSEL_FIELD;
        endcase
        case (eff_phase)
            PH_LINE_START:
            begin
                m_pos  = 5'd0;
                m_mask = 8'hFF;
            end
            PH_BLANK_CR:
            begin
                m_pos  = 5'd1;
                m_mask = 8'h00;
            end
            default:
            begin
                m_pos  = eff_pos;
                m_mask = eff_mask;
            end
        endcase
    end

    hrhp_match u_match (
        .tsel      (m_tsel),
        .pos       (m_pos),
        .mask      (m_mask),
        .byte_in   (byte_in),
        .mask_next (m_mask_next),
        .hit       (m_hit),
        .hit_idx   (m_idx)
    );

    // The step itself: line framing first, then the token rules, then the
    // handling of an ordinary token character.
    always_comb
    begin
        phase_next  = eff_phase;
        skip_next   = eff_skip;
        exempt_next = eff_exempt;
        pos_next    = eff_pos;
        mask_next   = eff_mask;
        field_next  = eff_field;
        cnt_next    = eff_cnt;
        fin_next    = eff_fin;
        step_res    = '0;
        tok         = 1'b0;
        tc          = 1'b0;
        tc_first    = 1'b0;
        err         = 1'b0;

        if (!eff_fin)
        begin
            if (eff_cnt == CNT_MAX)
            begin
                err = 1'b1;
            end
            else
            begin
                cnt_next = eff_cnt + LENGTH_BITS'(1);
                if (byte_in == CH_NUL)
                begin
                    err = 1'b1;
                end
                else
                begin
                    case (eff_phase)
                        PH_LF:
                        begin
                            if (byte_in != CH_LF)
                            begin
                                err = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_LINE_START;
                            end
                        end
                        PH_LINE_START:
                        begin
                            if (byte_in == CH_CR)
                            begin
                                phase_next = PH_BLANK_CR;
                            end
                            else
                            begin
                                phase_next  = PH_NAME;
                                skip_next   = 1'b1;
                                exempt_next = 1'b1;
                                pos_next    = 5'd0;
                                mask_next   = 8'hFF;
                                tok         = 1'b1;
                            end
                        end
                        PH_BLANK_CR:
                        begin
                            if (byte_in == CH_LF)
                            begin
                                step_res.valid     = 1'b1;
                                step_res.event_res = EV_DONE;
                                step_res.length    = LEN_OUT_BITS'(cnt_next);
                            end
                            else
                            begin
                                phase_next  = PH_NAME;
                                skip_next   = 1'b0;
                                exempt_next = 1'b0;
                                pos_next    = 5'd1;
                                mask_next   = 8'h00;
                                tok         = 1'b1;
                            end
                        end
                        default:
                        begin
                            tok = 1'b1;
                        end
                    endcase
                end
            end
        end

        // Token rules: spaces before a token, the exempt first byte, delimiters.
        if (tok)
        begin
            if (skip_next && byte_in == CH_SP)
            begin
                tc = 1'b0;
            end
            else if (skip_next || exempt_next)
            begin
                skip_next   = 1'b0;
                exempt_next = 1'b0;
                tc          = 1'b1;
                tc_first    = 1'b1;
            end
            else if (byte_in == CH_LF)
            begin
                err = 1'b1;
            end
            else if (byte_in == CH_SP)
            begin
                case (phase_next)
                    PH_VALUE:
                    begin
                        tc = 1'b1;
                    end
                    PH_METHOD:
                    begin
                        if (!m_hit)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            phase_next         = PH_URL;
                            pos_next           = 5'd0;
                            mask_next          = 8'hFF;
                            skip_next          = 1'b1;
                            exempt_next        = 1'b1;
                            step_res.valid     = 1'b1;
                            step_res.event_res = EV_METHOD;
                            step_res.code      = m_idx;
                        end
                    end
                    PH_URL:
                    begin
                        phase_next         = PH_VERSION;
                        pos_next           = 5'd0;
                        mask_next          = 8'hFF;
                        skip_next          = 1'b1;
                        exempt_next        = 1'b1;
                        step_res.valid     = 1'b1;
                        step_res.event_res = EV_URL_END;
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
            end
            else if (byte_in == CH_CR)
            begin
                case (phase_next)
                    PH_VERSION:
                    begin
                        if (!m_hit)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            phase_next         = PH_LF;
                            step_res.valid     = 1'b1;
                            step_res.event_res = EV_VERSION;
                            step_res.code      = m_idx;
                        end
                    end
                    PH_VALUE:
                    begin
                        phase_next = PH_LF;
                        if (eff_field < NO_FIELD)
                        begin
                            step_res.valid     = 1'b1;
                            step_res.event_res = EV_VALUE_END;
                            step_res.code      = eff_field[2:0];
                        end
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
            end
            else if (byte_in == CH_COLON && phase_next == PH_NAME)
            begin
                field_next  = m_hit ? {1'b0, m_idx} : NO_FIELD;
                phase_next  = PH_VALUE;
                pos_next    = 5'd0;
                mask_next   = 8'hFF;
                skip_next   = 1'b1;
                exempt_next = 1'b1;
            end
            else
            begin
                tc = 1'b1;
            end
        end

        // Ordinary token character: URL and value bytes stream out, name
        // characters narrow the candidate set.
        if (tc)
        begin
            case (phase_next)
                PH_URL:
                begin
                    if (tc_first && byte_in != CH_SLASH)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        step_res.valid     = 1'b1;
                        step_res.event_res = EV_URL_BYTE;
                        step_res.data      = byte_in;
                    end
                end
                PH_VALUE:
                begin
                    if (field_next < NO_FIELD)
                    begin
                        step_res.valid     = 1'b1;
                        step_res.event_res = EV_VALUE_BYTE;
                        step_res.code      = field_next[2:0];
                        step_res.data      = byte_in;
                    end
                end
                default:
                begin
                    mask_next = m_mask_next;
                    if (pos_next != POS_MAX)
                    begin
                        pos_next = pos_next + 5'd1;
                    end
                end
            endcase
        end

        if (err)
        begin
            step_res           = '0;
            step_res.valid     = 1'b1;
            step_res.event_res = EV_ERROR;
        end
        if (step_res.valid && (step_res.event_res == EV_DONE ||
                               step_res.event_res == EV_ERROR))
        begin
            fin_next = 1'b1;
        end
        step_res.valid = step_res.valid && adv;
    end

    // State registers move only when a byte is stepped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            skip_reg   <= 1'b0;
            exempt_reg <= 1'b0;
            pos_reg    <= 5'd0;
            mask_reg   <= 8'hFF;
            field_reg  <= NO_FIELD;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            exempt_reg <= exempt_next;
            pos_reg    <= pos_next;
            mask_reg   <= mask_next;
            field_reg  <= field_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Once a request has finished, only a start beat can produce another result.
    a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        adv && fin_reg && !start |-> !step_res.valid)
        else $error("result produced after request finished");

    // The header field code is either a table index or the no-field mark.
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= NO_FIELD)
        else $error("header field code out of range");

    // A done or error result always leaves the parser finished.
    a_finish_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step_res.valid && (step_res.event_res == EV_DONE ||
                           step_res.event_res == EV_ERROR) |=> fin_reg)
        else $error("terminal result did not finish the request");

    // The byte counter only grows within a request.
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !start |=> cnt_reg >= $past(cnt_reg))
        else $error("byte count went backwards");
`endif

endmodule

// ===== verif/tb_http_request_header_parser_core.sv =====
// Self-checking testbench of the HTTP request header parser core, with a predictor of its own.
module tb_http_request_header_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    // How a row of the opening table is checked.
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_QUIET   = 2'd1;
    localparam logic [1:0] ROW_TYPED   = 2'd2;

    // Ways of spoiling a generated request.
    localparam int MUT_REPLACE  = 0;
    localparam int MUT_CR       = 1;
    localparam int MUT_DROP     = 2;
    localparam int MUT_TRUNCATE = 3;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  code;
        logic [7:0]  data;
        logic [15:0] length;
    } parse_beat_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        s;
        logic [1:0]  kind;
        parse_beat_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hrhp_req_if req_ch ();
    hrhp_res_if res_ch ();

    http_request_header_parser_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Clock generation.
    always #CLK_HALF clk = ~clk;

    parse_beat_t expected_beats [$];
    logic [7:0]  req_bytes [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          stall_left     = 0;
    int          stretch_left   = 0;
    bit          busy_stretch   = 1'b0;

    // Parser state as the predictor sees it.
    logic [2:0]             ps_phase;
    bit                     ps_skip_sp;
    bit                     ps_exempt;
    logic [4:0]             ps_pos;
    logic [7:0]             ps_cands;
    logic [3:0]             ps_field;
    logic [LENGTH_BITS-1:0] ps_count;
    bit                     ps_finished;

    string method_names [7] = '{"GET", "POST", "HEAD", "PUT", "DELETE", "TRACE", "CONNECT"};
    string version_names [2] = '{"HTTP/1.0", "HTTP/1.1"};
    string field_names [8] = '{
        "Connection", "Upgrade", "Origin", "Sec-WebSocket-Key", "Sec-WebSocket-Extensions",
        "Sec-WebSocket-Accept", "Sec-WebSocket-Protocol", "Sec-WebSocket-Version"
    };

    // Opening sequence: a lower/upper case PUT request ending in a blank line, a byte after
    // completion, a NUL byte, an empty method and a slash that starts a new request.
    step_row_t opening_rows [24] = '{
        '{"p",      1'b1, ROW_QUIET,   '0},
        '{"U",      1'b0, ROW_QUIET,   '0},
        '{"t",      1'b0, ROW_QUIET,   '0},
        '{CH_SP,    1'b0, ROW_TYPED,   '{EV_METHOD, 3'd3, 8'd0, 16'd0}},
        '{CH_SP,    1'b0, ROW_QUIET,   '0},
        '{CH_SLASH, 1'b0, ROW_TYPED,   '{EV_URL_BYTE, 3'd0, CH_SLASH, 16'd0}},
        '{8'hFF,    1'b0, ROW_TYPED,   '{EV_URL_BYTE, 3'd0, 8'hFF, 16'd0}},
        '{CH_SP,    1'b0, ROW_TYPED,   '{EV_URL_END, 3'd0, 8'd0, 16'd0}},
        '{"h",      1'b0, ROW_PREDICT, '0},
        '{"T",      1'b0, ROW_PREDICT, '0},
        '{"t",      1'b0, ROW_PREDICT, '0},
        '{"P",      1'b0, ROW_PREDICT, '0},
        '{CH_SLASH, 1'b0, ROW_PREDICT, '0},
        '{"1",      1'b0, ROW_PREDICT, '0},
        '{".",      1'b0, ROW_PREDICT, '0},
        '{"0",      1'b0, ROW_PREDICT, '0},
        '{CH_CR,    1'b0, ROW_TYPED,   '{EV_VERSION, 3'd0, 8'd0, 16'd0}},
        '{CH_LF,    1'b0, ROW_QUIET,   '0},
        '{CH_CR,    1'b0, ROW_QUIET,   '0},
        '{CH_LF,    1'b0, ROW_TYPED,   '{EV_DONE, 3'd0, 8'd0, 16'd20}},
        '{"a",      1'b0, ROW_QUIET,   '0},
        '{CH_NUL,   1'b1, ROW_TYPED,   '{EV_ERROR, 3'd0, 8'd0, 16'd0}},
        '{CH_SP,    1'b1, ROW_TYPED,   '{EV_ERROR, 3'd0, 8'd0, 16'd0}},
        '{CH_SLASH, 1'b1, ROW_PREDICT, '0}
    };

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // Name k of the table that the current phase matches against, empty past its end.
    function automatic string table_entry(input int k);
        string nm;
        nm = "";
        if (ps_phase == PH_METHOD)
        begin
            if (k < 7)
                nm = method_names[k];
        end
        else if (ps_phase == PH_VERSION)
        begin
            if (k < 2)
                nm = version_names[k];
        end
        else
            nm = field_names[k];
        return nm;
    endfunction

    function automatic void clear_parser();
        ps_phase    = PH_METHOD;
        ps_skip_sp  = 1'b0;
        ps_exempt   = 1'b0;
        ps_pos      = '0;
        ps_cands    = 8'hFF;
        ps_field    = NO_FIELD;
        ps_count    = '0;
        ps_finished = 1'b0;
    endfunction

    function automatic void begin_token(input bit exempt);
        ps_pos     = '0;
        ps_cands   = 8'hFF;
        ps_skip_sp = exempt;
        ps_exempt  = exempt;
    endfunction

    // Drop every candidate name whose character at this position differs.
    function automatic void feed_name_char(input logic [7:0] b);
        string nm;
        for (int k = 0; k < 8; k++)
        begin
            nm = table_entry(k);
            if (ps_pos >= nm.len() || upcase(nm[ps_pos]) != upcase(b))
                ps_cands[k] = 1'b0;
        end
        if (ps_pos < POS_MAX)
            ps_pos = ps_pos + 5'd1;
    endfunction

    // First surviving candidate whose length equals the token length, or -1.
    function automatic int matched_entry();
        string nm;
        for (int k = 0; k < 8; k++)
        begin
            nm = table_entry(k);
            if (ps_cands[k] && nm.len() > 0 && nm.len() == ps_pos)
                return k;
        end
        return -1;
    endfunction

    function automatic bit report_beat(input logic [2:0] ev, input logic [2:0] cd,
                                       input logic [7:0] dt, input logic [15:0] ln,
                                       output parse_beat_t r);
        r = '{ev, cd, dt, ln};
        if (ev == EV_DONE || ev == EV_ERROR)
            ps_finished = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit token_char(input logic [7:0] b, input bit first, output parse_beat_t r);
        r = '0;
        if (ps_phase == PH_URL)
        begin
            if (first && b != CH_SLASH)
                return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
            return report_beat(EV_URL_BYTE, 3'd0, b, 16'd0, r);
        end
        if (ps_phase == PH_VALUE)
        begin
            if (ps_field < NO_FIELD)
                return report_beat(EV_VALUE_BYTE, ps_field[2:0], b, 16'd0, r);
            return 1'b0;
        end
        feed_name_char(b);
        return 1'b0;
    endfunction

    // One byte inside a token: leading spaces, delimiters and ordinary characters.
    function automatic bit token_byte(input logic [7:0] b, output parse_beat_t r);
        int m;
        r = '0;
        if (ps_skip_sp && b == CH_SP)
            return 1'b0;
        if (ps_skip_sp || ps_exempt)
        begin
            ps_skip_sp = 1'b0;
            ps_exempt  = 1'b0;
            return token_char(b, 1'b1, r);
        end
        if (b == CH_LF)
            return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
        if (b == CH_SP)
        begin
            if (ps_phase == PH_VALUE)
                return token_char(b, 1'b0, r);
            if (ps_phase == PH_METHOD)
            begin
                m = matched_entry();
                if (m < 0)
                    return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
                ps_phase = PH_URL;
                begin_token(1'b1);
                return report_beat(EV_METHOD, 3'(m), 8'd0, 16'd0, r);
            end
            if (ps_phase == PH_URL)
            begin
                ps_phase = PH_VERSION;
                begin_token(1'b1);
                return report_beat(EV_URL_END, 3'd0, 8'd0, 16'd0, r);
            end
            return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
        end
        if (b == CH_CR)
        begin
            if (ps_phase == PH_VERSION)
            begin
                m = matched_entry();
                if (m < 0)
                    return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
                ps_phase = PH_LF;
                return report_beat(EV_VERSION, 3'(m), 8'd0, 16'd0, r);
            end
            if (ps_phase == PH_VALUE)
            begin
                ps_phase = PH_LF;
                if (ps_field < NO_FIELD)
                    return report_beat(EV_VALUE_END, ps_field[2:0], 8'd0, 16'd0, r);
                return 1'b0;
            end
            return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
        end
        if (b == CH_COLON && ps_phase == PH_NAME)
        begin
            m = matched_entry();
            ps_field = (m < 0) ? NO_FIELD : 4'(m);
            ps_phase = PH_VALUE;
            begin_token(1'b1);
            return 1'b0;
        end
        return token_char(b, 1'b0, r);
    endfunction

    // Predicts the result of one accepted byte; taken is low when the byte is ignored.
    function automatic bit parse_step(input logic [7:0] b, input bit s, output parse_beat_t r,
                                      output bit taken);
        r     = '0;
        taken = 1'b0;
        if (s)
            clear_parser();
        if (ps_finished)
            return 1'b0;
        taken = 1'b1;
        if (ps_count >= COUNT_MAX)
            return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
        ps_count = ps_count + LENGTH_BITS'(1);
        if (b == CH_NUL)
            return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
        case (ps_phase)
            PH_LF:
            begin
                if (b != CH_LF)
                    return report_beat(EV_ERROR, 3'd0, 8'd0, 16'd0, r);
                ps_phase = PH_LINE_START;
                return 1'b0;
            end
            PH_LINE_START:
            begin
                if (b == CH_CR)
                begin
                    ps_phase = PH_BLANK_CR;
                    return 1'b0;
                end
                ps_phase = PH_NAME;
                begin_token(1'b1);
                return token_byte(b, r);
            end
            PH_BLANK_CR:
            begin
                if (b == CH_LF)
                    return report_beat(EV_DONE, 3'd0, 8'd0, 16'(ps_count), r);
                // The CR was not a blank line after all: it opens a header name.
                ps_phase = PH_NAME;
                begin_token(1'b0);
                feed_name_char(CH_CR);
                return token_byte(b, r);
            end
            default:
                return token_byte(b, r);
        endcase
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) && $urandom_range(0, 1))
            return c ^ 8'h20;
        return c;
    endfunction

    task automatic put_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            req_bytes.push_back(mixed_case(txt[i]));
    endtask

    task automatic put_spaces(input int least);
        int n;
        n = least;
        if ($urandom_range(0, 99) < 20)
            n = n + $urandom_range(1, 3);
        repeat (n) req_bytes.push_back(CH_SP);
    endtask

    // A name that is a prefix of a table name or one character longer.
    task automatic put_near_miss(input string nm);
        if ($urandom_range(0, 1))
            put_text(nm.substr(0, $urandom_range(0, nm.len() - 2)));
        else
        begin
            put_text(nm);
            req_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
    endtask

    task automatic put_header();
        int n;
        logic [7:0] c;
        // A CR at the start of a line that is not followed by LF opens a name.
        if ($urandom_range(0, 99) < 4)
            req_bytes.push_back(CH_CR);
        n = $urandom_range(0, 99);
        if (n < 60)
            put_text(field_names[$urandom_range(0, 7)]);
        else if (n < 75)
            put_near_miss(field_names[$urandom_range(0, 7)]);
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                c = 8'($urandom_range(8'h21, 8'h7E));
                req_bytes.push_back((c == CH_COLON) ? 8'h2D : c);
            end
        end
        req_bytes.push_back(CH_COLON);
        put_spaces(0);
        // An empty value swallows the CR and fails on the LF.
        if ($urandom_range(0, 99) >= 3)
        begin
            req_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
            repeat ($urandom_range(0, 9)) req_bytes.push_back(8'($urandom_range(8'h20, 8'hFF)));
        end
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endtask

    // A request with random content, mostly well formed, sometimes spoilt or plain noise.
    task automatic build_request();
        int cut;
        logic [7:0] c;
        req_bytes.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 16)) req_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 99) < 3)
            req_bytes.push_back(CH_SP);
        if ($urandom_range(0, 99) < 6)
            put_near_miss(method_names[$urandom_range(0, 6)]);
        else
            put_text(method_names[$urandom_range(0, 6)]);
        put_spaces(1);
        if ($urandom_range(0, 99) < 5)
        begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            req_bytes.push_back((c == CH_SLASH) ? 8'h78 : c);
        end
        else
            req_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(0, 10)) req_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
        put_spaces(1);
        if ($urandom_range(0, 99) < 5)
            put_near_miss(version_names[$urandom_range(0, 1)]);
        else
            put_text(version_names[$urandom_range(0, 1)]);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
        repeat ($urandom_range(0, 3)) put_header();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
        if ($urandom_range(0, 99) < 20)
        begin
            cut = $urandom_range(0, req_bytes.size() - 1);
            case ($urandom_range(0, 3))
                MUT_REPLACE:  req_bytes[cut] = 8'($urandom);
                MUT_CR:       req_bytes.insert(cut, CH_CR);
                MUT_DROP:     req_bytes.delete(cut);
                MUT_TRUNCATE:
                begin
                    while (req_bytes.size() > cut + 1)
                        void'(req_bytes.pop_back());
                end
                default: ;
            endcase
        end
    endtask

    // Drives one byte beat, waits for it to be taken and records what it should cause.
    task automatic send_byte(input logic [7:0] b, input bit s, input logic [1:0] kind,
                             input parse_beat_t want, output bit taken);
        int          gap;
        bit          has;
        parse_beat_t got;
        gap = busy_stretch ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid     <= 1'b0;
            req_ch.byte_req  <= 8'($urandom);
            req_ch.start_req <= 1'($urandom);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.byte_req  <= b;
        req_ch.start_req <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        has = parse_step(b, s, got, taken);
        if (kind == ROW_TYPED)
            expected_beats.push_back(want);
        else if (kind == ROW_PREDICT && has)
            expected_beats.push_back(got);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input parse_beat_t want,
                                 input parse_beat_t seen);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected event=%0d code=%0d data=%02h length=%0d,",
                     $time, what, want.event_res, want.code, want.data, want.length,
                     " got event=%0d code=%0d data=%02h length=%0d",
                     seen.event_res, seen.code, seen.data, seen.length);
    endtask

    // Result side: random stalls, with stretches where both sides run flat out.
    always @(negedge clk)
    begin
        int n;
        if (stretch_left == 0)
        begin
            busy_stretch <= ($urandom_range(0, 3) == 0);
            stretch_left <= $urandom_range(40, 300);
        end
        else
            stretch_left <= stretch_left - 1;
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            n = pick_gap();
            if (!busy_stretch && n > 0)
            begin
                stall_left   <= n - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Result checking and the watchdog on cycles without any beat.
    always @(posedge clk)
    begin
        parse_beat_t seen;
        parse_beat_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen = '{res_ch.event_res, res_ch.code, res_ch.data, res_ch.length};
                if (expected_beats.size() == 0)
                    flag_mismatch("result with nothing expected", '0, seen);
                else
                begin
                    want = expected_beats.pop_front();
                    if (seen !== want)
                        flag_mismatch("result mismatch", want, seen);
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[http_request_header_parser_core] ERROR");
                $finish;
            end
        end
    end

    // Stimulus: opening table, then random requests.
    initial
    begin
        bit taken;
        int items;
        items            = 0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.byte_req  = 8'd0;
        req_ch.start_req = 1'b0;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
            send_byte(opening_rows[i].b, opening_rows[i].s, opening_rows[i].kind,
                      opening_rows[i].want, taken);
        hold_until_drained();

        while (items < RANDOM_ITEMS)
        begin
            build_request();
            foreach (req_bytes[i])
            begin
                send_byte(req_bytes[i],
                          (i == 0) ? ($urandom_range(0, 99) < 95) : ($urandom_range(0, 99) == 0),
                          ROW_PREDICT, '0, taken);
                items++;
            end
            if ($urandom_range(0, 19) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("[http_request_header_parser_core] OK");
        else
            $display("[http_request_header_parser_core] ERROR");
        $finish;
    end

endmodule
